/* rtl/core/tlg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life engine package
// Field widths, operation codes, register indexes and default sizes shared by
// the channel interfaces, the core and the checker.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int OP_W        = 2;
    localparam int ROW_IDX_W   = 6;
    localparam int CELLS_W     = 64;
    localparam int DIM_W       = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 1;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

endpackage
`default_nettype wire

/* rtl/core/tlg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life engine channels
// Command channel (operation, row index, row cells) and result channel (read
// cells), each a valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface tlg_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [tlg_pkg::OP_W-1:0]         operation;
    logic [tlg_pkg::ROW_IDX_W-1:0]    row_index;
    logic [tlg_pkg::CELLS_W-1:0]      row_cells;

    modport source (output valid, operation, row_index, row_cells, input ready);
    modport sink   (input valid, operation, row_index, row_cells, output ready);
endinterface

interface tlg_res_if;
    logic                             valid;
    logic                             ready;
    logic [tlg_pkg::CELLS_W-1:0]      read_cells;

    modport source (output valid, read_cells, input ready);
    modport sink   (input valid, read_cells, output ready);
endinterface
`default_nettype wire

/* rtl/core/toroidal_life_generation_step_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Toroidal Life engine, rule B3/S23
// Board of row words in one RAM, written, advanced and read by commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the cmd channel: write a row, advance the board one
//   generation, or read a row. Every command returns exactly one beat on the
//   res channel; only a read returns nonzero cells.
//   board_height and board_width sit at APB addresses 0 and 4.
//   One command is in work at a time. A write or no-op goes straight to the
//   emit state, a read passes the read state first, and a generation reads
//   the rows through the single RAM read port, streaming them once in order.
//   The result sits in an output register, so the next command is taken while
//   a result still waits; a stalled receiver holds the block only once a
//   second result is ready.
//   After reset a clearing pass walks the RAM and zeroes every cell; after
//   every register write such a pass zeroes all cells outside the active
//   area. cmd.ready stays low meanwhile. A register write during the pass
//   restarts it.
// ----------------------------------------------------------------------------
module toroidal_life_generation_step_top #(
    parameter int MAX_ROWS = tlg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tlg_pkg::MAX_COLS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tlg_cmd_if.sink                                 cmd,
    tlg_res_if.source                               res,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tlg_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [tlg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [tlg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    localparam int NC    = MAX_COLS;
    localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SCW   = $clog2(MAX_ROWS + 1);
    localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int DW    = tlg_pkg::DIM_W;
    localparam int OUT_W = tlg_pkg::CELLS_W;
    localparam int PD_W  = tlg_pkg::APB_DATA_W;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_G_TOP,
        S_G_CUR,
        S_G_ROW,
        S_EMIT
    } state_t;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v, input int maxv);
        logic [DW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = DW'(maxv);
        end
        return r;
    endfunction

    function automatic logic [NC-1:0] wrap_left(input logic [NC-1:0] x,
                                                input logic [DW-1:0] wm1);
        logic [NC-1:0] l;
        l[0] = x[CIW'(wm1)];
        for (int c = 1; c < NC; c++)
        begin
            l[c] = x[c-1];
        end
        return l;
    endfunction

    function automatic logic [NC-1:0] wrap_right(input logic [NC-1:0] x,
                                                 input logic [DW-1:0] wm1);
        logic [NC-1:0] r;
        for (int c = 0; c < NC; c++)
        begin
            if (DW'(c) == wm1 || c + 1 >= NC)
            begin
                r[c] = x[0];
            end
            else
            begin
                r[c] = x[c+1];
            end
        end
        return r;
    endfunction

    function automatic logic [NC-1:0] dim_mask(input logic [DW-1:0] w);
        logic [NC-1:0] m;
        for (int c = 0; c < NC; c++)
        begin
            m[c] = (DW'(c) < w);
        end
        return m;
    endfunction

    state_t           state_reg, state_next;
    logic [DW-1:0]    h_reg, h_next;
    logic [DW-1:0]    w_reg, w_next;
    logic [DW-1:0]    clr_h_reg, clr_h_next;
    logic [DW-1:0]    clr_w_reg, clr_w_next;
    logic             pend_reg, pend_next;
    logic [SCW-1:0]   swp_reg, swp_next;
    logic             swp_wv_reg, swp_wv_next;
    logic [AW-1:0]    swp_wa_reg, swp_wa_next;
    logic [DW-1:0]    gen_i_reg, gen_i_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             out_valid_reg, out_valid_next;

    logic [NC-1:0]    prev_reg, prev_next;
    logic [NC-1:0]    cur_reg, cur_next;
    logic [NC-1:0]    top_reg, top_next;
    logic [NC-1:0]    emit_reg, emit_next;
    logic [NC-1:0]    out_data_reg, out_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [NC-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [NC-1:0]    ram_rdata;

    logic             cfg_wr;
    logic [tlg_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [DW-1:0]    h_eff, w_eff, hm1, wm1;
    logic [DW-1:0]    h_new_eff, w_new_eff;
    logic [NC-1:0]    w_mask, clr_mask;
    logic             cmd_acc;
    logic             out_load;
    logic             gen_last;
    logic [DW:0]      gen_ahead;
    logic [NC-1:0]    down_row;
    logic [NC-1:0]    ul, ur, cl, cr, dl, dr;
    logic [NC-1:0]    next_row;
    logic [3:0]       ncount;

    tlg_ram #(
        .WIDTH (NC),
        .DEPTH (MAX_ROWS)
    ) u_board (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[tlg_pkg::APB_ADDR_W-1:2];
    assign prdata  = (cfg_idx == tlg_pkg::REG_WIDTH) ? PD_W'(w_reg) : PD_W'(h_reg);

    assign h_next = (cfg_wr && cfg_idx == tlg_pkg::REG_HEIGHT) ? pwdata[DW-1:0] : h_reg;
    assign w_next = (cfg_wr && cfg_idx == tlg_pkg::REG_WIDTH)  ? pwdata[DW-1:0] : w_reg;

    assign h_eff     = eff_dim(h_reg, MAX_ROWS);
    assign w_eff     = eff_dim(w_reg, MAX_COLS);
    assign h_new_eff = eff_dim(h_next, MAX_ROWS);
    assign w_new_eff = eff_dim(w_next, MAX_COLS);
    assign hm1       = h_eff - DW'(1);
    assign wm1       = w_eff - DW'(1);
    assign w_mask    = dim_mask(w_eff);
    assign clr_mask  = dim_mask(clr_w_reg);

    assign cmd.ready      = (state_reg == S_IDLE) && !pend_reg;
    assign cmd_acc        = cmd.valid && cmd.ready;
    assign res.valid      = out_valid_reg;
    assign res.read_cells = OUT_W'(out_data_reg);

    assign gen_last  = (gen_i_reg == hm1);
    assign gen_ahead = {1'b0, gen_i_reg} + (DW+1)'(2);
    assign down_row  = gen_last ? top_reg : ram_rdata;

    always_comb
    begin
        ul = wrap_left(prev_reg, wm1);
        ur = wrap_right(prev_reg, wm1);
        cl = wrap_left(cur_reg, wm1);
        cr = wrap_right(cur_reg, wm1);
        dl = wrap_left(down_row, wm1);
        dr = wrap_right(down_row, wm1);
        next_row = '0;
        ncount   = '0;
        for (int c = 0; c < NC; c++)
        begin
            ncount = 4'(ul[c]) + 4'(prev_reg[c]) + 4'(ur[c]) + 4'(cl[c]) + 4'(cr[c])
                   + 4'(dl[c]) + 4'(down_row[c]) + 4'(dr[c]);
            next_row[c] = (ncount == 4'd3) || (cur_reg[c] && ncount == 4'd2);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg | (cfg_wr && state_reg != S_SWEEP);
        swp_next    = swp_reg;
        swp_wv_next = 1'b0;
        swp_wa_next = swp_wa_reg;
        gen_i_next  = gen_i_reg;
        rd_ok_next  = rd_ok_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        top_next    = top_reg;
        emit_next   = emit_reg;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        if (cfg_wr && (pend_reg || state_reg == S_SWEEP))
        begin
            clr_h_next = (h_new_eff < clr_h_reg) ? h_new_eff : clr_h_reg;
            clr_w_next = (w_new_eff < clr_w_reg) ? w_new_eff : clr_w_reg;
        end
        else if (cfg_wr)
        begin
            clr_h_next = h_new_eff;
            clr_w_next = w_new_eff;
        end
        else
        begin
            clr_h_next = clr_h_reg;
            clr_w_next = clr_w_reg;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                if (swp_wv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = swp_wa_reg;
                    ram_wdata = (int'(swp_wa_reg) < int'(clr_h_reg)) ?
                                (ram_rdata & clr_mask) : '0;
                end
                if (int'(swp_reg) < MAX_ROWS)
                begin
                    ram_raddr   = AW'(swp_reg);
                    swp_wv_next = 1'b1;
                    swp_wa_next = AW'(swp_reg);
                    swp_next    = swp_reg + SCW'(1);
                end
                else if (!swp_wv_reg && !cfg_wr)
                begin
                    state_next = S_IDLE;
                end
                if (cfg_wr)
                begin
                    swp_next = '0;
                end
            end
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    swp_next   = '0;
                    state_next = S_SWEEP;
                end
                else if (cmd_acc)
                begin
                    unique case (cmd.operation)
                        tlg_pkg::OP_WRITE:
                        begin
                            if ({1'b0, cmd.row_index} < h_eff)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(cmd.row_index);
                                ram_wdata = cmd.row_cells[NC-1:0] & w_mask;
                            end
                            emit_next  = '0;
                            state_next = S_EMIT;
                        end
                        tlg_pkg::OP_ADVANCE:
                        begin
                            ram_raddr  = AW'(hm1);
                            state_next = S_G_TOP;
                        end
                        tlg_pkg::OP_READ:
                        begin
                            ram_raddr  = AW'(cmd.row_index);
                            rd_ok_next = ({1'b0, cmd.row_index} < h_eff);
                            state_next = S_READ;
                        end
                        tlg_pkg::OP_NOP:
                        begin
                            emit_next  = '0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                emit_next  = rd_ok_reg ? ram_rdata : '0;
                state_next = S_EMIT;
            end
            S_G_TOP:
            begin
                prev_next  = ram_rdata;
                ram_raddr  = '0;
                state_next = S_G_CUR;
            end
            S_G_CUR:
            begin
                top_next   = ram_rdata;
                cur_next   = ram_rdata;
                gen_i_next = '0;
                ram_raddr  = (hm1 != '0) ? AW'(DW'(1)) : '0;
                state_next = S_G_ROW;
            end
            S_G_ROW:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(gen_i_reg);
                ram_wdata = next_row & w_mask;
                prev_next = cur_reg;
                cur_next  = down_row;
                if (gen_ahead < {1'b0, h_eff})
                begin
                    ram_raddr = AW'(gen_ahead);
                end
                if (gen_last)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    gen_i_next = gen_i_reg + DW'(1);
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        out_data_next = out_load ? emit_reg : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            h_reg         <= tlg_pkg::DIM_RESET;
            w_reg         <= tlg_pkg::DIM_RESET;
            clr_h_reg     <= '0;
            clr_w_reg     <= '0;
            pend_reg      <= 1'b0;
            swp_reg       <= '0;
            swp_wv_reg    <= 1'b0;
            swp_wa_reg    <= '0;
            gen_i_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            w_reg         <= w_next;
            clr_h_reg     <= clr_h_next;
            clr_w_reg     <= clr_w_next;
            pend_reg      <= pend_next;
            swp_reg       <= swp_next;
            swp_wv_reg    <= swp_wv_next;
            swp_wa_reg    <= swp_wa_next;
            gen_i_reg     <= gen_i_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        top_reg      <= top_next;
        emit_reg     <= emit_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

/* rtl/core/tlg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlg_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/tlg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life engine port checker
// Watches the top level's ports for result hold, command pacing, blocking
// after a register write, and register readback.
// ----------------------------------------------------------------------------
module tlg_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cmd_valid,
    input wire logic                              cmd_ready,
    input wire logic                              res_valid,
    input wire logic                              res_ready,
    input wire logic [tlg_pkg::CELLS_W-1:0]       read_cells,
    input wire logic                              psel,
    input wire logic                              penable,
    input wire logic                              pwrite,
    input wire logic [tlg_pkg::APB_ADDR_W-1:0]    paddr,
    input wire logic [tlg_pkg::APB_DATA_W-1:0]    pwdata,
    input wire logic [tlg_pkg::APB_DATA_W-1:0]    prdata,
    input wire logic                              pready
);

    localparam int DW = tlg_pkg::DIM_W;

    logic cfg_wr;
    logic height_wr;

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign height_wr = cfg_wr && (paddr[2] == tlg_pkg::REG_HEIGHT[0]);

    // A stalled result beat holds its cells.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(read_cells))
        else $error("result beat changed while stalled");

    // Only one command is in work at a time.
    a_cmd_pace: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in work");

    // A register write starts a clearing pass, which blocks commands.
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !cmd_ready)
        else $error("command channel open right after a register write");

    // The height register reads back what was written.
    a_height_rb: assert property (@(posedge clk) disable iff (!rst_n)
        height_wr |=> (paddr[2] != tlg_pkg::REG_HEIGHT[0])
                      || (prdata[DW-1:0] == $past(pwdata[DW-1:0])))
        else $error("height register readback mismatch");

endmodule

bind toroidal_life_generation_step_top tlg_checker u_tlg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .read_cells (res.read_cells),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);
`default_nettype wire

/* sim/tb_toroidal_life_generation_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the toroidal Life engine
// Loads boards of many sizes, advances them under rule B3/S23 with wraparound,
// and reads the rows back. A built-in board predictor produces the expected
// read data for every command, and a monitor compares each result beat with
// the oldest expected value. Both channels idle at random, and the receiver
// holds off for long stretches so that the block backs up and stalls.
// ----------------------------------------------------------------------------
module tb_toroidal_life_generation_step_top;

    localparam int MAX_ROWS    = tlg_pkg::MAX_ROWS_DEF;
    localparam int MAX_COLS    = tlg_pkg::MAX_COLS_DEF;
    localparam int CELLS_W     = tlg_pkg::CELLS_W;
    localparam int ROW_IDX_W   = tlg_pkg::ROW_IDX_W;
    localparam int DIM_W       = tlg_pkg::DIM_W;
    localparam int APB_ADDR_W  = tlg_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = tlg_pkg::APB_DATA_W;
    localparam int REG_IDX_W   = tlg_pkg::REG_IDX_W;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_FIXED   = 11;
    localparam int NUM_RANDOM  = 3;

    typedef struct packed {
        tlg_pkg::op_t         op;
        logic [ROW_IDX_W-1:0] row;
        logic [CELLS_W-1:0]   cells;
    } life_cmd_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    tlg_cmd_if cmd_ch();
    tlg_res_if res_ch();

    toroidal_life_generation_step_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Board image and size registers as the block should hold them.
    logic [CELLS_W-1:0] life_rows [MAX_ROWS];
    logic [DIM_W-1:0]   cfg_height;
    logic [DIM_W-1:0]   cfg_width;

    life_cmd_t          pending_cmds [$];
    logic [CELLS_W-1:0] expected_cells [$];
    life_cmd_t          in_flight;
    logic [CELLS_W-1:0] predicted;

    logic [DIM_W-1:0] phase_h [NUM_FIXED] = '{1, 2, 3, 64, 1, 0, 127, 5, 100, 2, 64};
    logic [DIM_W-1:0] phase_w [NUM_FIXED] = '{1, 2, 3, 1, 64, 0, 127, 9, 70, 64, 2};

    bit idle_on;
    int planned_total;
    int cmds_taken;
    int advances_taken;
    int reads_taken;
    int res_beats;
    int fail_count;
    int sizes_tried;
    int send_gap;
    int recv_gap;
    int hold_left;
    int holds_done;
    int quiet_cycles;

    function automatic int clamp_dim(input logic [DIM_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [CELLS_W-1:0] col_mask(input int w);
        if (w >= CELLS_W)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [CELLS_W-1:0] evolve_row(input logic [CELLS_W-1:0] up,
                                                      input logic [CELLS_W-1:0] cur,
                                                      input logic [CELLS_W-1:0] down,
                                                      input int w);
        logic [CELLS_W-1:0] next;
        int cols [3];
        int n;
        next = '0;
        for (int c = 0; c < w; c++)
        begin
            cols[0] = (c + w - 1) % w;
            cols[1] = c;
            cols[2] = (c + 1) % w;
            n = 0;
            for (int k = 0; k < 3; k++)
                n += up[cols[k]] + cur[cols[k]] + down[cols[k]];
            n -= cur[c];
            if ((cur[c] && (n == 2 || n == 3)) || (!cur[c] && n == 3))
                next[c] = 1'b1;
        end
        return next;
    endfunction

    function automatic void step_generation();
        int h;
        int w;
        logic [CELLS_W-1:0] m;
        logic [CELLS_W-1:0] top;
        logic [CELLS_W-1:0] prev;
        logic [CELLS_W-1:0] cur;
        logic [CELLS_W-1:0] down;
        h = clamp_dim(cfg_height, MAX_ROWS);
        w = clamp_dim(cfg_width, MAX_COLS);
        m = col_mask(w);
        top = life_rows[0] & m;
        prev = life_rows[h-1] & m;
        for (int i = 0; i < h; i++)
        begin
            cur = life_rows[i] & m;
            down = (i + 1 < h) ? (life_rows[i+1] & m) : top;
            life_rows[i] = evolve_row(prev, cur, down, w) & m;
            prev = cur;
        end
    endfunction

    function automatic logic [CELLS_W-1:0] apply_cmd(input life_cmd_t item);
        int h;
        logic [CELLS_W-1:0] m;
        h = clamp_dim(cfg_height, MAX_ROWS);
        m = col_mask(clamp_dim(cfg_width, MAX_COLS));
        case (item.op)
            tlg_pkg::OP_WRITE:
            begin
                if (item.row < h)
                    life_rows[item.row] = item.cells & m;
            end
            tlg_pkg::OP_ADVANCE:
                step_generation();
            tlg_pkg::OP_READ:
            begin
                if (item.row < h)
                    return life_rows[item.row] & m;
            end
            default:
                ;
        endcase
        return '0;
    endfunction

    function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [APB_DATA_W-1:0] data);
        int h;
        logic [CELLS_W-1:0] m;
        if (idx == tlg_pkg::REG_HEIGHT)
            cfg_height = data[DIM_W-1:0];
        else
            cfg_width = data[DIM_W-1:0];
        h = clamp_dim(cfg_height, MAX_ROWS);
        m = col_mask(clamp_dim(cfg_width, MAX_COLS));
        for (int i = 0; i < MAX_ROWS; i++)
            life_rows[i] = (i < h) ? (life_rows[i] & m) : '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CELLS_W-1:0] rand_cells();
        logic [CELLS_W-1:0] a;
        logic [CELLS_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return a & b;
            1: return a | b;
            2: return a & b & {$urandom, $urandom};
            3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    function automatic void queue_cmd(input tlg_pkg::op_t op, input int row,
                                      input logic [CELLS_W-1:0] cells);
        life_cmd_t item;
        item.op = op;
        item.row = row[ROW_IDX_W-1:0];
        item.cells = cells;
        pending_cmds = {pending_cmds, item};
        planned_total++;
    endfunction

    // Mostly whole-board loads followed by generations and reads, with some
    // stray commands of any kind mixed in.
    function automatic void plan_phase(input int budget);
        int h;
        int n;
        h = clamp_dim(cfg_height, MAX_ROWS);
        n = 0;
        while (n < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                for (int r = 0; r < h && n < budget; r++)
                begin
                    queue_cmd(tlg_pkg::OP_WRITE, r, rand_cells());
                    n++;
                end
                repeat ($urandom_range(1, 3))
                begin
                    queue_cmd(tlg_pkg::OP_ADVANCE, $urandom_range(0, 63), rand_cells());
                    n++;
                    repeat ($urandom_range(0, 3))
                    begin
                        queue_cmd(tlg_pkg::OP_READ, $urandom_range(0, h - 1), rand_cells());
                        n++;
                    end
                end
                for (int r = 0; r < h && n < budget; r++)
                begin
                    queue_cmd(tlg_pkg::OP_READ, r, rand_cells());
                    n++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    queue_cmd(tlg_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                              rand_cells());
                    n++;
                end
            end
        end
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[DIM_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (res_beats < planned_total)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_board(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w);
        if ($urandom_range(0, 1) != 0)
        begin
            apb_write(tlg_pkg::REG_HEIGHT, h);
            apb_write(tlg_pkg::REG_WIDTH, w);
        end
        else
        begin
            apb_write(tlg_pkg::REG_WIDTH, w);
            apb_write(tlg_pkg::REG_HEIGHT, h);
        end
        sizes_tried++;
    endtask

    function automatic int phase_budget();
        return (clamp_dim(cfg_height, MAX_ROWS) > 32) ? 130 : 90;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predicted = apply_cmd(in_flight);
                expected_cells = {expected_cells, predicted};
                cmds_taken++;
                if (in_flight.op == tlg_pkg::OP_ADVANCE)
                    advances_taken++;
                if (in_flight.op == tlg_pkg::OP_READ)
                    reads_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_flight = pending_cmds.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.operation <= in_flight.op;
                    cmd_ch.row_index <= in_flight.row;
                    cmd_ch.row_cells <= in_flight.cells;
                    send_gap = idle_on ? pick_gap() : 0;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        logic [CELLS_W-1:0] want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res_beats <= res_beats + 1;
                if (expected_cells.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result beat with nothing outstanding, read_cells=%h",
                                 res_ch.read_cells);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (res_ch.read_cells !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: beat %0d read_cells expected %h, got %h",
                                     res_beats, want, res_ch.read_cells);
                    end
                end
                if (idle_on)
                    recv_gap = pick_gap();
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && res_beats >= 300) ||
                 (holds_done == 1 && res_beats >= 1100))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no beat for %0d cycles, %0d results still outstanding",
                     QUIET_LIMIT, planned_total - res_beats);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = tlg_pkg::OP_NOP;
        cmd_ch.row_index = '0;
        cmd_ch.row_cells = '0;
        res_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cfg_height       = tlg_pkg::DIM_RESET;
        cfg_width        = tlg_pkg::DIM_RESET;
        for (int i = 0; i < MAX_ROWS; i++)
            life_rows[i] = '0;
        idle_on        = 1'b1;
        planned_total  = 0;
        cmds_taken     = 0;
        advances_taken = 0;
        reads_taken    = 0;
        res_beats      = 0;
        fail_count     = 0;
        sizes_tried    = 1;
        quiet_cycles   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size board straight out of reset: extremes, wraparound at the
        // corners and edges, and the no-op operation code.
        queue_cmd(tlg_pkg::OP_READ, 0, '0);
        queue_cmd(tlg_pkg::OP_WRITE, 0, '1);
        queue_cmd(tlg_pkg::OP_READ, 0, '1);
        queue_cmd(tlg_pkg::OP_WRITE, 63, 64'h8000_0000_0000_0001);
        queue_cmd(tlg_pkg::OP_READ, 63, '0);
        queue_cmd(tlg_pkg::OP_WRITE, 1, '0);
        queue_cmd(tlg_pkg::OP_NOP, 63, '1);
        queue_cmd(tlg_pkg::OP_ADVANCE, 0, '0);
        queue_cmd(tlg_pkg::OP_READ, 0, '0);
        queue_cmd(tlg_pkg::OP_READ, 1, '0);
        queue_cmd(tlg_pkg::OP_READ, 63, '0);
        queue_cmd(tlg_pkg::OP_WRITE, 20, 64'h0000_0000_0070_0000);
        queue_cmd(tlg_pkg::OP_WRITE, 4, 64'h0000_0000_0000_0001);
        queue_cmd(tlg_pkg::OP_WRITE, 5, 64'h8000_0000_0000_0001);
        queue_cmd(tlg_pkg::OP_WRITE, 6, 64'h8000_0000_0000_0000);
        queue_cmd(tlg_pkg::OP_ADVANCE, 63, '1);
        queue_cmd(tlg_pkg::OP_READ, 4, '0);
        queue_cmd(tlg_pkg::OP_READ, 5, '0);
        queue_cmd(tlg_pkg::OP_READ, 6, '0);
        queue_cmd(tlg_pkg::OP_READ, 19, '0);
        queue_cmd(tlg_pkg::OP_READ, 20, '0);
        queue_cmd(tlg_pkg::OP_READ, 21, '0);
        queue_cmd(tlg_pkg::OP_ADVANCE, 0, '0);
        queue_cmd(tlg_pkg::OP_READ, 20, '0);
        plan_phase(phase_budget());
        wait_drained();

        for (int p = 0; p < NUM_FIXED + NUM_RANDOM; p++)
        begin
            idle_on = (p % 4 != 2);
            if (p < NUM_FIXED)
                set_board(phase_h[p], phase_w[p]);
            else
                set_board(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 64)));
            plan_phase(phase_budget());
            wait_drained();
        end

        repeat (80) @(posedge clk);
        if (expected_cells.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d expected results never arrived", expected_cells.size());
        end
        $display("Ran %0d commands (%0d generations, %0d row reads) on %0d board sizes.",
                 cmds_taken, advances_taken, reads_taken, sizes_tried);
        $display("Checked %0d result beats with %0d long receiver hold-offs, %0d failures.",
                 res_beats, holds_done, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/tlg_pkg.sv
rtl/core/tlg_if.sv
rtl/core/tlg_ram.sv
rtl/core/toroidal_life_generation_step_top.sv
rtl/core/tlg_checker.sv
sim/tb_toroidal_life_generation_step_top.sv
